// File: sv/lazy_segment_tree_add_assign_defines.svh
// assertion macros for the lazy segment tree checker
`ifndef LAZY_SEGMENT_TREE_ADD_ASSIGN_DEFINES_SVH
`define LAZY_SEGMENT_TREE_ADD_ASSIGN_DEFINES_SVH

// valid held with stable payload while stalled
`define LST_ASSERT_HOLD(lbl, vld, rdy, dat) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(dat))) else $error("transfer not held");

// generic property under reset
`define LST_ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property failed");

`endif

// File: sv/lst_pkg.sv
// types, constants and node helpers for the lazy segment tree
package lst_pkg;

  localparam int unsigned SLOTS_DEF = 32768;
  localparam int unsigned CW        = 17;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_ASSIGN = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [31:0] MIN_ID = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] range_low;
    logic [14:0] range_high;
    logic signed [31:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] range_min;
    logic signed [47:0] range_sum;
  } out_t;

  typedef struct packed {
    logic [31:0] mn;
    logic [47:0] tot;
    logic [31:0] pa;
    logic        ia;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  function automatic rec_t compose(rec_t c, logic [31:0] amt, logic add);
    rec_t o;
    o = c;
    if (add) begin
      o.pa = c.pa + amt;
    end else begin
      o.pa = amt;
      o.ia = 1'b0;
    end
    return o;
  endfunction

endpackage

// File: sv/lazy_segment_tree_add_assign.sv
// lazy segment tree with range add, range assign and range min/sum query
//
// Input channel in_valid/in_ready/in_data carries one request: add, assign
// or query over an inclusive slot range. Result channel out_valid/out_ready/
// out_data carries range_min and range_sum, one transfer per query only.
// Add, assign and unused action codes give no result.
// All node state sits in one single-port memory of 4*SLOTS entries; a walk
// of the tree runs under a sequencer with an explicit stack, one memory
// access per cycle. An inner node steps through read, load, multiply,
// settle, two child read-modify-writes, write back and decide; a leaf skips
// the child steps; the walk then returns and resumes through the stack. An
// update re-settles each covered node and, on the way back, gathers the
// children of each inner node it split. A request touches about 4 nodes per level.
// in_ready is high only while the sequencer is idle with no result waiting.
// After reset a clearing pass writes every memory entry with in_ready low.
// A finished query raises a result-waiting flag, and from idle the result
// moves to the output register once that is free; while the receiver stalls
// with a result held there, the next query result waits and in_ready stays low.
module lazy_segment_tree_add_assign #(
  parameter int unsigned SLOTS = lst_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lst_pkg::out_t out_data
);
  import lst_pkg::*;

  localparam int unsigned DEPTH = 4 * SLOTS;
  localparam int unsigned NW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned LW    = $clog2(SLOTS + 1);
  localparam int unsigned SD    = SW + 1;
  localparam int unsigned PW    = $clog2(SD);

  typedef enum logic [15:0] {
    S_CLR  = 16'h0001, S_IDLE = 16'h0002, S_RD   = 16'h0004, S_LD   = 16'h0008,
    S_MUL  = 16'h0010, S_SET  = 16'h0020, S_C0R  = 16'h0040, S_C0W  = 16'h0080,
    S_C1R  = 16'h0100, S_C1W  = 16'h0200, S_WN   = 16'h0400, S_DEC  = 16'h0800,
    S_RET  = 16'h1000, S_RES  = 16'h2000, S_G0R  = 16'h4000, S_G1   = 16'h8000
  } st_t;

  st_t st_r, st_nxt;
  logic fin_r, fin_nxt;
  logic g0_r, g0_nxt;

  logic [NW-1:0] cn_r, cn_nxt;
  logic [SW-1:0] cl_r, cl_nxt, cr_r, cr_nxt;
  logic          ph_r, ph_nxt;
  logic [PW-1:0] sp_r, sp_nxt;
  logic [NW-1:0] stn_r [SD];
  logic [SW-1:0] stl_r [SD];
  logic [SW-1:0] str_r [SD];
  logic          stp_r [SD];
  logic          push;
  logic          push_ph;

  logic [1:0]  op_r, op_nxt;
  logic [14:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0] val_r, val_nxt;
  rec_t        cur_r, cur_nxt, ga_r, ga_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic [31:0] samt_r, samt_nxt;
  logic        sadd_r, sadd_nxt;
  logic        sec_r, sec_nxt;
  logic [31:0] amin_r, amin_nxt;
  logic [47:0] asum_r, asum_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  out_t        od_r, od_nxt;

  logic          mem_we;
  logic [NW-1:0] mem_addr;
  rec_t          mem_wd;
  logic [REC_W-1:0] mem_rd_raw;
  rec_t          mem_rd;

  logic [NW-1:0] ch0, ch1;
  logic [SW:0]   lsum;
  logic [SW-1:0] mid;
  logic [LW-1:0] len;
  logic signed [32:0] lenx;
  logic signed [64:0] prod_full;
  logic [CW-1:0] l_x, r_x, lo_x, hi_x;
  logic outside, covered;
  logic [PW-1:0] sp_m1;

  lst_mem #(.DEPTH(DEPTH), .AW(NW), .DW(REC_W)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(REC_W'(mem_wd)), .rdata(mem_rd_raw)
  );
  assign mem_rd = rec_t'(mem_rd_raw);

  assign ch0  = NW'({cn_r, 1'b0});
  assign ch1  = NW'({cn_r, 1'b1});
  assign lsum = {1'b0, cl_r} + {1'b0, cr_r};
  assign mid  = lsum[SW:1];
  assign len  = LW'({1'b0, cr_r} - {1'b0, cl_r} + 1'b1);
  assign lenx = $signed(33'(len));
  assign prod_full = $signed(cur_r.pa) * lenx;
  assign l_x  = CW'(cl_r);
  assign r_x  = CW'(cr_r);
  assign lo_x = CW'(lo_r);
  assign hi_x = CW'(hi_r);
  assign outside = (r_x < lo_x) || (l_x > hi_x);
  assign covered = (lo_x <= l_x) && (r_x <= hi_x);
  assign sp_m1   = sp_r - 1'b1;

  assign in_ready  = (st_r == S_IDLE) && !fin_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    st_nxt = st_r; fin_nxt = fin_r; g0_nxt = g0_r;
    cn_nxt = cn_r; cl_nxt = cl_r; cr_nxt = cr_r; ph_nxt = ph_r; sp_nxt = sp_r;
    op_nxt = op_r; lo_nxt = lo_r; hi_nxt = hi_r; val_nxt = val_r;
    cur_nxt = cur_r; ga_nxt = ga_r; prod_nxt = prod_r;
    samt_nxt = samt_r; sadd_nxt = sadd_r; sec_nxt = sec_r;
    amin_nxt = amin_r; asum_nxt = asum_r; clr_nxt = clr_r;
    ov_nxt = ov_r; od_nxt = od_r;
    push = 1'b0; push_ph = 1'b0;
    mem_we = 1'b0; mem_addr = cn_r; mem_wd = cur_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      S_CLR: begin
        mem_we = 1'b1; mem_addr = clr_r;
        mem_wd = '{mn: 32'd0, tot: 48'd0, pa: 32'd0, ia: 1'b1};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NW'(DEPTH - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (fin_r) begin
          if (!ov_r || out_ready) begin
            ov_nxt = 1'b1; fin_nxt = 1'b0;
            od_nxt.range_min = amin_r; od_nxt.range_sum = asum_r;
          end
        end else if (in_valid) begin
          op_nxt = in_data.action; lo_nxt = in_data.range_low;
          hi_nxt = in_data.range_high; val_nxt = in_data.operand_value;
          cn_nxt = NW'(1); cl_nxt = '0; cr_nxt = SW'(SLOTS - 1);
          sp_nxt = '0; sec_nxt = 1'b0;
          amin_nxt = MIN_ID; asum_nxt = '0;
          if (in_data.range_high >= in_data.range_low) begin
            if (in_data.action == ACT_ADD || in_data.action == ACT_ASSIGN ||
                in_data.action == ACT_QUERY) begin
              st_nxt = S_RD;
            end
          end else if (in_data.action == ACT_QUERY) begin
            fin_nxt = 1'b1;
          end
        end
      end
      S_RD: st_nxt = S_LD;
      S_LD: begin
        cur_nxt = mem_rd; st_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = prod_full[47:0]; st_nxt = S_SET;
      end
      S_SET: begin
        samt_nxt = cur_r.pa; sadd_nxt = cur_r.ia;
        if (cur_r.ia) begin
          cur_nxt.mn  = cur_r.mn + cur_r.pa;
          cur_nxt.tot = cur_r.tot + prod_r;
        end else begin
          cur_nxt.mn  = cur_r.pa;
          cur_nxt.tot = prod_r;
        end
        cur_nxt.pa = '0; cur_nxt.ia = 1'b1;
        st_nxt = (cl_r != cr_r) ? S_C0R : S_WN;
      end
      S_C0R: begin
        mem_addr = ch0; st_nxt = S_C0W;
      end
      S_C0W: begin
        mem_addr = ch0; mem_we = 1'b1; mem_wd = compose(mem_rd, samt_r, sadd_r);
        st_nxt = S_C1R;
      end
      S_C1R: begin
        mem_addr = ch1; st_nxt = S_C1W;
      end
      S_C1W: begin
        mem_addr = ch1; mem_we = 1'b1; mem_wd = compose(mem_rd, samt_r, sadd_r);
        st_nxt = S_WN;
      end
      S_WN: begin
        mem_we = 1'b1; st_nxt = S_DEC;
      end
      S_DEC: begin
        if (sec_r || outside) begin
          st_nxt = S_RET;
        end else if (covered) begin
          if (op_r == ACT_QUERY) begin
            if ($signed(cur_r.mn) < $signed(amin_r)) begin
              amin_nxt = cur_r.mn;
            end
            asum_nxt = asum_r + cur_r.tot;
            st_nxt = S_RET;
          end else begin
            cur_nxt.pa = val_r; cur_nxt.ia = (op_r == ACT_ADD);
            sec_nxt = 1'b1; st_nxt = S_MUL;
          end
        end else begin
          push = 1'b1; push_ph = 1'b0; sp_nxt = sp_r + 1'b1;
          cn_nxt = ch0; cr_nxt = mid; st_nxt = S_RD;
        end
      end
      S_RET: begin
        sec_nxt = 1'b0;
        if (sp_r == '0) begin
          st_nxt = S_IDLE;
          if (op_r == ACT_QUERY) begin
            fin_nxt = 1'b1;
          end
        end else begin
          cn_nxt = stn_r[sp_m1[PW-1:0]]; cl_nxt = stl_r[sp_m1];
          cr_nxt = str_r[sp_m1]; ph_nxt = stp_r[sp_m1];
          sp_nxt = sp_m1; st_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!ph_r) begin
          push = 1'b1; push_ph = 1'b1; sp_nxt = sp_r + 1'b1;
          cn_nxt = ch1; cl_nxt = mid + 1'b1; st_nxt = S_RD;
        end else if (op_r == ACT_QUERY) begin
          st_nxt = S_RET;
        end else begin
          g0_nxt = 1'b0; st_nxt = S_G0R;
        end
      end
      S_G0R: begin
        if (!g0_r) begin
          mem_addr = ch0; g0_nxt = 1'b1;
        end else begin
          mem_addr = ch1; ga_nxt = mem_rd; st_nxt = S_G1;
        end
      end
      S_G1: begin
        mem_we = 1'b1;
        mem_wd.mn  = ($signed(mem_rd.mn) < $signed(ga_r.mn)) ? mem_rd.mn : ga_r.mn;
        mem_wd.tot = ga_r.tot + mem_rd.tot;
        mem_wd.pa  = '0; mem_wd.ia = 1'b1;
        st_nxt = S_RET;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; sp_r <= '0; ov_r <= 1'b0; fin_r <= 1'b0;
      sec_r <= 1'b0; g0_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; sp_r <= sp_nxt; ov_r <= ov_nxt;
      fin_r <= fin_nxt; sec_r <= sec_nxt; g0_r <= g0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cn_r <= cn_nxt; cl_r <= cl_nxt; cr_r <= cr_nxt; ph_r <= ph_nxt;
    op_r <= op_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; val_r <= val_nxt;
    cur_r <= cur_nxt; ga_r <= ga_nxt; prod_r <= prod_nxt;
    samt_r <= samt_nxt; sadd_r <= sadd_nxt;
    amin_r <= amin_nxt; asum_r <= asum_nxt; od_r <= od_nxt;
    if (push) begin
      stn_r[sp_r] <= cn_r; stl_r[sp_r] <= cl_r; str_r[sp_r] <= cr_r;
      stp_r[sp_r] <= push_ph;
    end
  end
endmodule

// File: sv/lst_mem.sv
// single-port node memory with registered read
module lst_mem #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned AW    = 2,
  parameter int unsigned DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/lst_chk.sv
// port-level checker for the lazy segment tree, bound to the top level
`include "lazy_segment_tree_add_assign_defines.svh"

module lst_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input lst_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input lst_pkg::out_t out_data
);
  import lst_pkg::*;

  `LST_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_data)
  `LST_ASSERT_PROP(a_query_busy, (in_valid && in_ready && in_data.action == ACT_QUERY) |=> !in_ready)
  `LST_ASSERT_PROP(a_result_after_busy, $rose(out_valid) |-> $past(!in_ready))
endmodule

bind lazy_segment_tree_add_assign lst_chk u_lst_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
